/* rtl/robd_pkg.sv */
// Package: types, constants and the per-bit decode step of the object stream decoder.
`timescale 1ns / 1ps
package robd_pkg;

    localparam int MaxRes = 4;

    typedef enum logic [3:0] {
        PH_HDR_LEAD = 4'd0,
        PH_HDR_TC   = 4'd1,
        PH_TOP      = 4'd2,
        PH_LIT      = 4'd3,
        PH_TYPE     = 4'd4,
        PH_LINK     = 4'd5,
        PH_CODE     = 4'd6,
        PH_VTYPE    = 4'd7,
        PH_VAL      = 4'd8,
        PH_NLEN     = 4'd9,
        PH_NCHAR    = 4'd10,
        PH_DONE     = 4'd11,
        PH_ERROR    = 4'd12
    } phase_t;

    localparam logic [2:0] EV_LIT   = 3'd0;
    localparam logic [2:0] EV_LINK  = 3'd1;
    localparam logic [2:0] EV_ITEM  = 3'd2;
    localparam logic [2:0] EV_CHAR  = 3'd3;
    localparam logic [2:0] EV_DONE  = 3'd4;
    localparam logic [2:0] EV_ERROR = 3'd5;

    localparam logic [3:0] ERR_HEADER     = 4'd1;
    localparam logic [3:0] ERR_SECOND     = 4'd2;
    localparam logic [3:0] ERR_CODE       = 4'd3;
    localparam logic [3:0] ERR_DUP_DATA   = 4'd4;
    localparam logic [3:0] ERR_DUP_CODE   = 4'd5;
    localparam logic [3:0] ERR_EARLY_LOC  = 4'd6;
    localparam logic [3:0] ERR_LOC_TYPE   = 4'd7;
    localparam logic [3:0] ERR_CHAIN_TYPE = 4'd8;
    localparam logic [3:0] ERR_OVERFLOW   = 4'd9;
    localparam logic [3:0] ERR_TRUNC      = 4'd10;
    localparam logic [3:0] ERR_NO_SIZE    = 4'd11;

    localparam logic [3:0] SP_NAME     = 4'd0;
    localparam logic [3:0] SP_MODULE   = 4'd2;
    localparam logic [3:0] SP_CHAIN    = 4'd6;
    localparam logic [3:0] SP_ENTRY    = 4'd7;
    localparam logic [3:0] SP_DSIZE    = 4'd10;
    localparam logic [3:0] SP_SETLOC   = 4'd11;
    localparam logic [3:0] SP_CSIZE    = 4'd13;
    localparam logic [3:0] SP_ENDMOD   = 4'd14;
    localparam logic [3:0] SP_ENDFILE  = 4'd15;

    localparam logic [1:0] VT_CODE = 2'd1;
    localparam logic [1:0] VT_DATA = 2'd2;

    typedef struct packed {
        phase_t      phase;
        logic [15:0] acc;
        logic [4:0]  bits_left;
        logic [3:0]  code;
        logic [1:0]  ctype;
        logic [2:0]  nlen;
        logic [2:0]  nidx;
        logic        seg;
        logic [15:0] ccnt;
        logic [15:0] dcnt;
        logic [15:0] csize;
        logic [15:0] dsize;
        logic [1:0]  flags;
        logic        fin;
        logic        err;
    } st_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic        seg;
        logic [15:0] loc;
        logic [15:0] val;
        logic [1:0]  vt;
        logic [3:0]  code;
        logic [7:0]  ch;
        logic [2:0]  pos;
        logic [3:0]  err;
        logic        last;
    } res_t;

    typedef struct packed {
        st_t  st;
        logic emit;
        res_t res;
        logic stop;
    } fin_t;

    typedef struct packed {
        st_t        st;
        logic [1:0] n;
        res_t       r0;
        res_t       r1;
        logic       stop;
    } step_t;

    function automatic res_t err_res(logic [3:0] e);
        res_t r;
        r = '0;
        r.kind = EV_ERROR;
        r.err = e;
        return r;
    endfunction

    function automatic st_t fail_st(st_t s);
        st_t t;
        t = s;
        t.err = 1'b1;
        t.phase = PH_ERROR;
        return t;
    endfunction

    function automatic st_t start(st_t s, phase_t p, logic [4:0] nb);
        st_t t;
        t = s;
        t.phase = p;
        t.bits_left = nb;
        t.acc = '0;
        return t;
    endfunction

    function automatic logic has_value(logic [3:0] c);
        return c == SP_CHAIN || c == SP_ENTRY || c == SP_DSIZE || c == SP_SETLOC
            || c == SP_CSIZE || c == SP_ENDMOD;
    endfunction

    function automatic logic takes_name(logic [3:0] c);
        return c == SP_NAME || c == SP_CHAIN || c == SP_ENTRY;
    endfunction

    function automatic fin_t finish(st_t s, logic [15:0] val);
        fin_t f;
        f.st = s;
        f.emit = 1'b0;
        f.res = '0;
        f.stop = 1'b0;
        case (s.code)
            SP_CHAIN: begin
                if (s.ctype != VT_CODE && s.ctype != VT_DATA) begin
                    f.emit = 1'b1; f.res = err_res(ERR_CHAIN_TYPE);
                end
            end
            SP_DSIZE: begin
                if (s.flags[1]) begin
                    f.emit = 1'b1; f.res = err_res(ERR_DUP_DATA);
                end else begin
                    f.st.dsize = val; f.st.flags[1] = 1'b1;
                end
            end
            SP_CSIZE: begin
                if (s.flags[0]) begin
                    f.emit = 1'b1; f.res = err_res(ERR_DUP_CODE);
                end else begin
                    f.st.csize = val; f.st.flags[0] = 1'b1;
                end
            end
            SP_SETLOC: begin
                if (s.flags != 2'b11) begin
                    f.emit = 1'b1; f.res = err_res(ERR_EARLY_LOC);
                end else if (s.ctype == VT_CODE) begin
                    f.st.seg = 1'b0; f.st.ccnt = val;
                end else if (s.ctype == VT_DATA) begin
                    f.st.seg = 1'b1; f.st.dcnt = val;
                end else begin
                    f.emit = 1'b1; f.res = err_res(ERR_LOC_TYPE);
                end
            end
            SP_ENDMOD: f.stop = 1'b1;
            SP_ENDFILE: begin
                f.emit = 1'b1;
                if (s.flags != 2'b11) begin
                    f.res = err_res(ERR_NO_SIZE);
                end else begin
                    f.res = '0;
                    f.res.kind = EV_DONE;
                end
            end
            default: ;
        endcase
        if (f.emit && f.res.kind == EV_ERROR) begin
            f.st = fail_st(f.st);
            f.stop = 1'b1;
        end else if (s.code == SP_ENDFILE) begin
            f.st.fin = 1'b1;
            f.st.phase = PH_DONE;
            f.stop = 1'b1;
        end else begin
            f.st = start(f.st, PH_TOP, 5'd1);
        end
        return f;
    endfunction

    function automatic step_t after_header(step_t r, logic [15:0] val);
        step_t t;
        fin_t  f;
        t = r;
        t.r0 = '0;
        t.r0.kind = EV_ITEM;
        t.r0.val = val;
        t.r0.vt = t.st.ctype;
        t.r0.code = t.st.code;
        t.n = 2'd1;
        if (takes_name(t.st.code) || t.st.code == SP_MODULE) begin
            t.st = start(t.st, PH_NLEN, 5'd3);
        end else begin
            f = finish(t.st, val);
            t.st = f.st;
            t.stop = f.stop;
            if (f.emit) begin
                t.r1 = f.res;
                t.n = 2'd2;
            end
        end
        return t;
    endfunction

    function automatic step_t feed(st_t s, logic b);
        step_t       r;
        fin_t        f;
        logic [15:0] acc;
        logic [15:0] off;
        logic [15:0] size;
        logic [16:0] off1;
        logic        seg;
        r.st = s;
        r.n = 2'd0;
        r.r0 = '0;
        r.r1 = '0;
        r.stop = 1'b0;
        acc = {s.acc[14:0], b};
        r.st.acc = acc;
        if (s.bits_left > 5'd1) begin
            r.st.bits_left = s.bits_left - 5'd1;
            return r;
        end
        r.st.bits_left = '0;
        seg = s.seg;
        off = seg ? s.dcnt : s.ccnt;
        size = seg ? s.dsize : s.csize;
        off1 = {1'b0, off} + 17'd1;
        case (s.phase)
            PH_HDR_LEAD: begin
                if (acc[0]) r.st = start(r.st, PH_HDR_TC, 5'd6);
                else begin r.n = 2'd1; r.r0 = err_res(ERR_HEADER); end
            end
            PH_HDR_TC: begin
                if (acc[5:0] != 6'd2) begin
                    r.n = 2'd1; r.r0 = err_res(ERR_HEADER);
                end else begin
                    r.st.code = SP_MODULE;
                    r.st.ctype = '0;
                    r = after_header(r, 16'd0);
                end
            end
            PH_TOP: begin
                if (acc[0]) r.st = start(r.st, PH_TYPE, 5'd2);
                else r.st = start(r.st, PH_LIT, 5'd8);
            end
            PH_LIT: begin
                if (off >= size) begin
                    r.n = 2'd1; r.r0 = err_res(ERR_OVERFLOW);
                end else begin
                    r.n = 2'd1;
                    r.r0.kind = EV_LIT; r.r0.seg = seg; r.r0.loc = off;
                    r.r0.val = {8'd0, acc[7:0]};
                    if (seg) r.st.dcnt = s.dcnt + 16'd1;
                    else r.st.ccnt = s.ccnt + 16'd1;
                    r.st = start(r.st, PH_TOP, 5'd1);
                end
            end
            PH_TYPE: begin
                if (acc[1:0] != 2'd0) begin
                    r.st.ctype = acc[1:0];
                    r.st = start(r.st, PH_LINK, 5'd16);
                end else begin
                    r.st = start(r.st, PH_CODE, 5'd4);
                end
            end
            PH_LINK: begin
                if (off1 >= {1'b0, size}) begin
                    r.n = 2'd1; r.r0 = err_res(ERR_OVERFLOW);
                end else begin
                    r.n = 2'd1;
                    r.r0.kind = EV_LINK; r.r0.seg = seg; r.r0.loc = off;
                    r.r0.val = {acc[7:0], acc[15:8]};
                    r.r0.vt = s.ctype;
                    if (seg) r.st.dcnt = s.dcnt + 16'd2;
                    else r.st.ccnt = s.ccnt + 16'd2;
                    r.st = start(r.st, PH_TOP, 5'd1);
                end
            end
            PH_CODE: begin
                r.st.code = acc[3:0];
                r.st.ctype = '0;
                if (acc[3:0] == SP_MODULE) begin
                    r.n = 2'd1; r.r0 = err_res(ERR_SECOND);
                end else if (!has_value(acc[3:0]) && !takes_name(acc[3:0])
                             && acc[3:0] != SP_ENDFILE) begin
                    r.n = 2'd1; r.r0 = err_res(ERR_CODE);
                end else if (has_value(acc[3:0])) begin
                    r.st = start(r.st, PH_VTYPE, 5'd2);
                end else begin
                    r = after_header(r, 16'd0);
                end
            end
            PH_VTYPE: begin
                r.st.ctype = acc[1:0];
                r.st = start(r.st, PH_VAL, 5'd16);
            end
            PH_VAL: r = after_header(r, {acc[7:0], acc[15:8]});
            PH_NLEN: begin
                r.st.nlen = acc[2:0];
                r.st.nidx = '0;
                if (acc[2:0] == 3'd0) begin
                    f = finish(r.st, 16'd0);
                    r.st = f.st; r.stop = f.stop;
                    if (f.emit) begin r.n = 2'd1; r.r0 = f.res; end
                end else begin
                    r.st = start(r.st, PH_NCHAR, 5'd8);
                end
            end
            PH_NCHAR: begin
                r.n = 2'd1;
                r.r0.kind = EV_CHAR; r.r0.code = s.code;
                r.r0.ch = acc[7:0]; r.r0.pos = s.nidx;
                r.st.nidx = s.nidx + 3'd1;
                if (r.st.nidx >= s.nlen) begin
                    f = finish(r.st, 16'd0);
                    r.st = f.st; r.stop = f.stop;
                    if (f.emit) begin r.n = 2'd2; r.r1 = f.res; end
                end else begin
                    r.st = start(r.st, PH_NCHAR, 5'd8);
                end
            end
            default: r.stop = 1'b1;
        endcase
        if (r.n != 2'd0 && r.r0.kind == EV_ERROR) begin
            r.st = fail_st(r.st);
            r.stop = 1'b1;
        end
        return r;
    endfunction

endpackage

/* rtl/relocatable_object_bitstream_decoder.sv */
// Top level of the relocatable object bitstream decoder.
// Channel | Ports                              | Transfer
// input   | s_valid s_ready s_rel_byte ...     | one stream byte with flags
// result  | m_valid m_ready m_event_kind ...   | one decoded event
// A byte is registered, decoded combinationally and its 0..4 results loaded
// into a result buffer, drained one per cycle while m_ready is high. A byte
// occupies the buffer until a new byte loads as its last result transfers.
// Reset (aresetn low, synchronous) clears parse state and empties the buffer.
`timescale 1ns / 1ps
module relocatable_object_bitstream_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rel_byte,
    input  logic        s_module_start,
    input  logic        s_stream_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_event_kind,
    output logic        m_segment,
    output logic [15:0] m_location,
    output logic [15:0] m_item_value,
    output logic [1:0]  m_value_type,
    output logic [3:0]  m_item_code,
    output logic [7:0]  m_name_char,
    output logic [2:0]  m_name_pos,
    output logic [3:0]  m_error_code,
    output logic        m_last
);
    import robd_pkg::*;

    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       ms_reg;
    logic       se_reg;
    logic       can_load;
    logic       load;
    res_t       res [MaxRes];
    logic [2:0] res_cnt;
    res_t       m_res;

    assign load    = in_valid_reg && can_load;
    assign s_ready = !in_valid_reg || load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            byte_reg <= s_rel_byte;
            ms_reg   <= s_module_start;
            se_reg   <= s_stream_end;
        end
    end

    robd_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (load),
        .rel_byte     (byte_reg),
        .module_start (ms_reg),
        .stream_end   (se_reg),
        .res          (res),
        .res_cnt      (res_cnt)
    );

    robd_outbuf u_outbuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .res      (res),
        .res_cnt  (res_cnt),
        .can_load (can_load),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_res    (m_res)
    );

    assign m_event_kind = m_res.kind;
    assign m_segment    = m_res.seg;
    assign m_location   = m_res.loc;
    assign m_item_value = m_res.val;
    assign m_value_type = m_res.vt;
    assign m_item_code  = m_res.code;
    assign m_name_char  = m_res.ch;
    assign m_name_pos   = m_res.pos;
    assign m_error_code = m_res.err;
    assign m_last       = m_res.last;

endmodule

/* rtl/robd_core.sv */
// Decode core: parse state register and the eight-bit decode of one byte.
`timescale 1ns / 1ps
module robd_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  logic [7:0]          rel_byte,
    input  logic                module_start,
    input  logic                stream_end,
    output robd_pkg::res_t      res [robd_pkg::MaxRes],
    output logic [2:0]          res_cnt
);
    import robd_pkg::*;

    st_t   st_reg;
    st_t   st_next;
    step_t stp;
    res_t  r_tmp [MaxRes];
    logic  stop;
    logic [2:0] cnt;

    always_comb begin
        st_next = st_reg;
        if (module_start) st_next = '0;
        cnt = '0;
        stop = 1'b0;
        stp = '0;
        for (int j = 0; j < MaxRes; j++) r_tmp[j] = '0;
        if (!st_next.err && !st_next.fin) begin
            for (int i = 0; i < 8; i++) begin
                if (!stop) begin
                    stp = feed(st_next, rel_byte[7 - i]);
                    st_next = stp.st;
                    stop = stp.stop;
                    for (int j = 0; j < MaxRes; j++) begin
                        if (stp.n != 2'd0 && cnt == 3'(j)) r_tmp[j] = stp.r0;
                        if (stp.n == 2'd2 && cnt == 3'(j - 1)) r_tmp[j] = stp.r1;
                    end
                    if (cnt < 3'(MaxRes)) cnt = cnt + 3'(stp.n);
                end
            end
        end
        if (stream_end && !st_next.fin && !st_next.err) begin
            for (int j = 0; j < MaxRes; j++) begin
                if (cnt == 3'(j)) r_tmp[j] = err_res(ERR_TRUNC);
            end
            st_next = fail_st(st_next);
            if (cnt < 3'(MaxRes)) cnt = cnt + 3'd1;
        end
        for (int j = 0; j < MaxRes; j++) begin
            if (cnt == 3'(j + 1)) r_tmp[j].last = 1'b1;
        end
    end

    assign res = r_tmp;
    assign res_cnt = cnt;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '0;
        end else if (load) begin
            st_reg <= st_next;
        end
    end

endmodule

/* rtl/robd_outbuf.sv */
// Result buffer: holds the results of one byte and hands them out one per transfer.
`timescale 1ns / 1ps
module robd_outbuf (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  robd_pkg::res_t      res [robd_pkg::MaxRes],
    input  logic [2:0]          res_cnt,
    output logic                can_load,
    output logic                m_valid,
    input  logic                m_ready,
    output robd_pkg::res_t      m_res
);
    import robd_pkg::*;

    res_t       buf_reg [MaxRes];
    logic [2:0] cnt_reg;
    logic [2:0] rd_reg;

    assign m_valid  = rd_reg < cnt_reg;
    assign m_res    = buf_reg[rd_reg[1:0]];
    assign can_load = !m_valid || (m_ready && (rd_reg + 3'd1 == cnt_reg));

    always_ff @(posedge aclk) begin
        if (load) buf_reg <= res;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            rd_reg  <= '0;
        end else if (load) begin
            cnt_reg <= res_cnt;
            rd_reg  <= '0;
        end else if (m_valid && m_ready) begin
            rd_reg  <= rd_reg + 3'd1;
        end
    end

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the relocatable object bitstream decoder.
`timescale 1ns / 1ps
module tb_top;
    import robd_pkg::*;

    typedef struct {
        logic [7:0] b;
        logic       ms;
        logic       se;
        bit         hold;
    } stream_byte_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [7:0]  s_rel_byte = 0;
    logic        s_module_start = 0;
    logic        s_stream_end = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [2:0]  m_event_kind;
    logic        m_segment;
    logic [15:0] m_location;
    logic [15:0] m_item_value;
    logic [1:0]  m_value_type;
    logic [3:0]  m_item_code;
    logic [7:0]  m_name_char;
    logic [2:0]  m_name_pos;
    logic [3:0]  m_error_code;
    logic        m_last;

    relocatable_object_bitstream_decoder dut (.*);

    initial forever #5 aclk = ~aclk;

    stream_byte_t byte_q[$];
    res_t         event_q[$];
    bit           bit_q[$];
    res_t         byte_events[$];
    bit           next_hold;
    int           errors, bytes_sent, events_seen, total_bytes;
    int           send_gap, recv_gap, long_hold;
    bit           long_hold_done, stim_done;

    // decoder shadow state
    phase_t      ph;
    logic [15:0] acc, ccnt, dcnt, csize, dsize;
    logic [4:0]  left;
    logic [3:0]  icode;
    logic [1:0]  ity, flags;
    logic [2:0]  nlen, nidx;
    logic        seg, fin, errl;
    bit          stop;

    function automatic bit valued(logic [3:0] c);
        return c == SP_CHAIN || c == SP_ENTRY || c == SP_DSIZE || c == SP_SETLOC
            || c == SP_CSIZE || c == SP_ENDMOD;
    endfunction

    function automatic bit named(logic [3:0] c);
        return c == SP_NAME || c == SP_CHAIN || c == SP_ENTRY;
    endfunction

    task automatic clear_decoder();
        ph = PH_HDR_LEAD; acc = 0; left = 0; icode = 0; ity = 0; nlen = 0; nidx = 0;
        seg = 0; ccnt = 0; dcnt = 0; csize = 0; dsize = 0; flags = 0; fin = 0; errl = 0;
    endtask

    task automatic post(logic [2:0] k, logic sg, logic [15:0] loc, logic [15:0] v,
                        logic [1:0] vt, logic [3:0] c, logic [7:0] ch, logic [2:0] pos,
                        logic [3:0] e);
        res_t r;
        r = '0;
        r.kind = k; r.seg = sg; r.loc = loc; r.val = v; r.vt = vt;
        r.code = c; r.ch = ch; r.pos = pos; r.err = e;
        if (byte_events.size() < MaxRes) byte_events.push_back(r);
    endtask

    task automatic raise(logic [3:0] e);
        post(EV_ERROR, 0, 0, 0, 0, 0, 0, 0, e);
        errl = 1; ph = PH_ERROR; stop = 1;
    endtask

    task automatic arm(phase_t p, logic [4:0] n);
        ph = p; left = n; acc = 0;
    endtask

    task automatic close_item(logic [15:0] v);
        case (icode)
            SP_CHAIN: if (ity != VT_CODE && ity != VT_DATA) begin raise(ERR_CHAIN_TYPE); return; end
            SP_DSIZE: begin
                if (flags[1]) begin raise(ERR_DUP_DATA); return; end
                dsize = v; flags[1] = 1;
            end
            SP_CSIZE: begin
                if (flags[0]) begin raise(ERR_DUP_CODE); return; end
                csize = v; flags[0] = 1;
            end
            SP_SETLOC: begin
                if (flags != 2'b11) begin raise(ERR_EARLY_LOC); return; end
                if (ity == VT_CODE) begin seg = 0; ccnt = v; end
                else if (ity == VT_DATA) begin seg = 1; dcnt = v; end
                else begin raise(ERR_LOC_TYPE); return; end
            end
            SP_ENDMOD: stop = 1;
            SP_ENDFILE: begin
                if (flags != 2'b11) begin raise(ERR_NO_SIZE); return; end
                post(EV_DONE, 0, 0, 0, 0, 0, 0, 0, 0);
                fin = 1; ph = PH_DONE; stop = 1;
                return;
            end
            default: ;
        endcase
        arm(PH_TOP, 1);
    endtask

    task automatic item_header(logic [15:0] v);
        post(EV_ITEM, 0, 0, v, ity, icode, 0, 0, 0);
        if (named(icode) || icode == SP_MODULE) arm(PH_NLEN, 3);
        else close_item(v);
    endtask

    task automatic shift_bit(logic b);
        logic [15:0] off, sz, a;
        acc = {acc[14:0], b};
        if (left > 1) begin left--; return; end
        left = 0;
        a = acc;
        off = seg ? dcnt : ccnt;
        sz = seg ? dsize : csize;
        case (ph)
            PH_HDR_LEAD: if (a[0]) arm(PH_HDR_TC, 6); else raise(ERR_HEADER);
            PH_HDR_TC: begin
                if (a[5:0] != 6'd2) raise(ERR_HEADER);
                else begin icode = SP_MODULE; ity = 0; item_header(0); end
            end
            PH_TOP: if (a[0]) arm(PH_TYPE, 2); else arm(PH_LIT, 8);
            PH_LIT: begin
                if (off >= sz) raise(ERR_OVERFLOW);
                else begin
                    post(EV_LIT, seg, off, {8'd0, a[7:0]}, 0, 0, 0, 0, 0);
                    if (seg) dcnt++; else ccnt++;
                    arm(PH_TOP, 1);
                end
            end
            PH_TYPE: if (a[1:0] != 0) begin ity = a[1:0]; arm(PH_LINK, 16); end
                     else arm(PH_CODE, 4);
            PH_LINK: begin
                if ({1'b0, off} + 17'd1 >= {1'b0, sz}) raise(ERR_OVERFLOW);
                else begin
                    post(EV_LINK, seg, off, {a[7:0], a[15:8]}, ity, 0, 0, 0, 0);
                    if (seg) dcnt += 2; else ccnt += 2;
                    arm(PH_TOP, 1);
                end
            end
            PH_CODE: begin
                icode = a[3:0]; ity = 0;
                if (icode == SP_MODULE) raise(ERR_SECOND);
                else if (!valued(icode) && !named(icode) && icode != SP_ENDFILE)
                    raise(ERR_CODE);
                else if (valued(icode)) arm(PH_VTYPE, 2);
                else item_header(0);
            end
            PH_VTYPE: begin ity = a[1:0]; arm(PH_VAL, 16); end
            PH_VAL: item_header({a[7:0], a[15:8]});
            PH_NLEN: begin
                nlen = a[2:0]; nidx = 0;
                if (nlen == 0) close_item(0); else arm(PH_NCHAR, 8);
            end
            PH_NCHAR: begin
                post(EV_CHAR, 0, 0, 0, 0, icode, a[7:0], nidx, 0);
                nidx++;
                if (nidx >= nlen) close_item(0); else arm(PH_NCHAR, 8);
            end
            default: stop = 1;
        endcase
    endtask

    task automatic decode_byte(logic [7:0] b, logic ms, logic se);
        byte_events.delete();
        stop = 0;
        if (ms) clear_decoder();
        if (!errl && !fin)
            for (int i = 7; i >= 0 && !stop; i--) shift_bit(b[i]);
        if (se && !fin && !errl) raise(ERR_TRUNC);
        if (byte_events.size() > 0) byte_events[$].last = 1;
        foreach (byte_events[i]) event_q.push_back(byte_events[i]);
    endtask

    // bitstream builder
    task automatic put(logic [15:0] v, int n);
        for (int i = n - 1; i >= 0; i--) bit_q.push_back(v[i]);
    endtask

    task automatic put_val(logic [15:0] v);
        put(v[7:0], 8);
        put(v[15:8], 8);
    endtask

    task automatic special(logic [3:0] c, logic [1:0] ty, logic [15:0] v, int nl);
        put(1, 1); put(0, 2); put(c, 4);
        if (valued(c)) begin put(ty, 2); put_val(v); end
        if (named(c) || c == SP_MODULE) begin
            put(nl, 3);
            repeat (nl) put($urandom_range(0, 255), 8);
        end
        if (c == SP_ENDMOD) while (bit_q.size() % 8 != 0) bit_q.push_back(0);
    endtask

    task automatic lit(logic [7:0] v);
        put(0, 1); put(v, 8);
    endtask

    task automatic link(logic [1:0] t, logic [15:0] v);
        put(1, 1); put(t, 2); put_val(v);
    endtask

    task automatic flush(bit se);
        stream_byte_t sb;
        while (bit_q.size() % 8 != 0) bit_q.push_back(0);
        for (int i = 0; i < bit_q.size(); i += 8) begin
            sb.b = {bit_q[i], bit_q[i+1], bit_q[i+2], bit_q[i+3],
                    bit_q[i+4], bit_q[i+5], bit_q[i+6], bit_q[i+7]};
            sb.ms = (i == 0);
            sb.se = se && (i + 8 >= bit_q.size());
            sb.hold = next_hold && i == 0;
            byte_q.push_back(sb);
        end
        next_hold = 0;
        bit_q.delete();
    endtask

    task automatic opener(int cs, int ds);
        special(SP_MODULE, 0, 0, $urandom_range(0, 1));
        if (cs >= 0) special(SP_CSIZE, $urandom_range(0, 3), cs, 0);
        if (ds >= 0) special(SP_DSIZE, $urandom_range(0, 3), ds, 0);
    endtask

    task automatic random_module();
        int n, r;
        opener($urandom_range(0, 40), $urandom_range(0, 40));
        n = $urandom_range(3, 14);
        repeat (n) begin
            r = $urandom_range(0, 19);
            if (r < 8) lit($urandom_range(0, 255));
            else if (r < 12) link($urandom_range(1, 3), $urandom_range(0, 65535));
            else if (r < 14) special(SP_SETLOC, ($urandom_range(0, 7) == 0) ?
                                     $urandom_range(0, 3) : $urandom_range(1, 2),
                                     $urandom_range(0, 36), 0);
            else if (r < 16) special($urandom_range(0, 1) ? SP_ENTRY : SP_NAME,
                                     $urandom_range(0, 3), $urandom_range(0, 65535),
                                     $urandom_range(0, 7));
            else if (r == 16) special(SP_CHAIN, ($urandom_range(0, 3) == 0) ?
                                      $urandom_range(0, 3) : $urandom_range(1, 2),
                                      $urandom_range(0, 65535), $urandom_range(0, 3));
            else if (r == 17) special(SP_ENDMOD, $urandom_range(0, 3),
                                      $urandom_range(0, 65535), 0);
            else if (r == 18 && $urandom_range(0, 3) == 0)
                special($urandom_range(0, 15), $urandom_range(0, 3),
                        $urandom_range(0, 65535), $urandom_range(0, 2));
            else lit($urandom_range(0, 255));
        end
        if ($urandom_range(0, 9) != 0) special(SP_ENDFILE, 0, 0, 0);
        flush($urandom_range(0, 7) == 0);
    endtask

    task automatic noise(int n);
        stream_byte_t sb;
        repeat (n) begin
            sb.b = $urandom_range(0, 255);
            sb.ms = $urandom_range(0, 3) == 0;
            sb.se = $urandom_range(0, 3) == 0;
            sb.hold = 0;
            byte_q.push_back(sb);
        end
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch on %s: got %0h expected %0h at %0t", what, got, want, $time);
        errors++;
    endtask

    initial begin
        // full well-formed module
        opener(20, 10);
        special(SP_SETLOC, VT_CODE, 3, 0);
        lit(8'hff); lit(8'h00);
        link(1, 16'hffff); link(3, 16'h0000);
        special(SP_SETLOC, VT_DATA, 0, 0);
        lit(8'h5a);
        special(SP_ENTRY, 0, 16'h1234, 7);
        special(SP_NAME, 0, 0, 0);
        special(SP_CHAIN, VT_DATA, 16'hbeef, 2);
        special(SP_ENDMOD, 0, 0, 0);
        lit(8'h81);
        special(SP_ENDFILE, 0, 0, 0);
        flush(0);
        put(0, 8); flush(0);
        put(1, 1); put(5, 6); flush(0);
        opener(-1, -1); special(SP_MODULE, 0, 0, 0); flush(0);
        opener(-1, -1); special(4'd3, 0, 0, 0); flush(0);
        opener(-1, 4); special(SP_DSIZE, 0, 1, 0); flush(0);
        opener(4, -1); special(SP_CSIZE, 0, 1, 0); flush(0);
        opener(4, -1); special(SP_SETLOC, VT_CODE, 0, 0); flush(0);
        opener(4, 4); special(SP_SETLOC, 2'd3, 0, 0); flush(0);
        opener(-1, -1); special(SP_CHAIN, 2'd0, 0, 1); flush(0);
        opener(0, -1); lit(8'h11); flush(0);
        opener(1, -1); link(2, 16'h55aa); flush(0);
        opener(4, -1); special(SP_ENDFILE, 0, 0, 0); flush(0);
        opener(4, -1); lit(1); flush(1);
        noise(4);
        total_bytes = byte_q.size() + 8;
        next_hold = 1;
        while (byte_q.size() < total_bytes) begin
            if ($urandom_range(0, 5) == 0) noise($urandom_range(1, 4));
            else random_module();
        end
        total_bytes = byte_q.size();
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        wait (stim_done);
        wait (event_q.size() == 0);
        repeat (20) @(posedge aclk);
        $display("decoded %0d stream bytes into %0d events", bytes_sent, events_seen);
        $display("covered modules, all item kinds, error paths and back-pressure");
        if (errors == 0) $display("[relocatable_object_bitstream_decoder] OK");
        else $display("[relocatable_object_bitstream_decoder] ERROR");
        $finish;
    end

    initial begin
        #3ms;
        $display("[relocatable_object_bitstream_decoder] ERROR");
        $finish;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 0;
            clear_decoder();
        end else begin
            if (s_valid && s_ready) begin
                decode_byte(s_rel_byte, s_module_start, s_stream_end);
                bytes_sent++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 0;
                end else if (byte_q.size() > 0 && !(byte_q[0].hold && event_q.size() > 0)) begin
                    s_valid <= 1;
                    s_rel_byte <= byte_q[0].b;
                    s_module_start <= byte_q[0].ms;
                    s_stream_end <= byte_q[0].se;
                    void'(byte_q.pop_front());
                    if (byte_q.size() > 25 && $urandom_range(0, 7) == 0)
                        send_gap = $urandom_range(1, 10);
                end else begin
                    s_valid <= 0;
                    if (byte_q.size() == 0) stim_done <= 1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        res_t want;
        if (!aresetn) begin
            m_ready <= 0;
        end else begin
            if (m_valid && m_ready) begin
                events_seen++;
                if (event_q.size() == 0) begin
                    report("unexpected transfer", m_event_kind, 0);
                end else begin
                    want = event_q.pop_front();
                    if (m_event_kind !== want.kind) report("event_kind", m_event_kind, want.kind);
                    if (m_segment !== want.seg) report("segment", m_segment, want.seg);
                    if (m_location !== want.loc) report("location", m_location, want.loc);
                    if (m_item_value !== want.val) report("item_value", m_item_value, want.val);
                    if (m_value_type !== want.vt) report("value_type", m_value_type, want.vt);
                    if (m_item_code !== want.code) report("item_code", m_item_code, want.code);
                    if (m_name_char !== want.ch) report("name_char", m_name_char, want.ch);
                    if (m_name_pos !== want.pos) report("name_pos", m_name_pos, want.pos);
                    if (m_error_code !== want.err) report("error_code", m_error_code, want.err);
                    if (m_last !== want.last) report("last", m_last, want.last);
                end
            end
            if (!long_hold_done && events_seen >= 40) begin
                long_hold_done = 1;
                long_hold = 150;
            end
            if (long_hold > 0) begin
                long_hold--;
                m_ready <= 0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 0;
            end else begin
                m_ready <= 1;
                if (byte_q.size() > 25 && $urandom_range(0, 7) == 0)
                    recv_gap = $urandom_range(1, 10);
            end
        end
    end

endmodule
